// ===== sv/itte_pkg.sv =====
// Shared constants, opcodes and controller/datapath handoff types for the tree traversal engine.
package itte_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int OP_W         = 3;
    localparam int DATA_W       = 32;

    // Command opcodes
    localparam logic [OP_W-1:0] OP_INORDER   = 3'd0;
    localparam logic [OP_W-1:0] OP_PREORDER  = 3'd1;
    localparam logic [OP_W-1:0] OP_POSTORDER = 3'd2;
    localparam logic [OP_W-1:0] OP_APPEND    = 3'd3;
    localparam logic [OP_W-1:0] OP_HEIGHT    = 3'd4;
    localparam logic [OP_W-1:0] OP_BSTCHK    = 3'd5;

    // Cursor moves
    localparam logic [1:0] POS_HOLD  = 2'd0;
    localparam logic [1:0] POS_LEFT  = 2'd1;
    localparam logic [1:0] POS_RIGHT = 2'd2;
    localparam logic [1:0] POS_UP    = 2'd3;

    // Output register source
    localparam logic [1:0] OSEL_PREV   = 2'd0;
    localparam logic [1:0] OSEL_APPEND = 2'd1;
    localparam logic [1:0] OSEL_HEIGHT = 2'd2;
    localparam logic [1:0] OSEL_BST    = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic       take;       // command beat: reset walk state
        logic       append;     // store value if there is room
        logic [1:0] pos_op;     // cursor move
        logic       rd_en;      // read node store
        logic       rd_parent;  // read parent of cursor instead of cursor
        logic       consume;    // read data becomes the held value
        logic       out_load;   // load output register
        logic [1:0] out_sel;
        logic       out_last;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic node_null;   // cursor past the last stored node
        logic node_root;   // cursor at node 1
        logic node_right;  // cursor is a right child
        logic prev_vld;    // a visited value is held
        logic out_free;    // output register can take a beat
    } dp_status_t;

endpackage

// ===== sv/itte_if.sv =====
// Valid/ready channel interfaces for the command and result streams.
interface itte_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [itte_pkg::OP_W-1:0]           opcode;
    logic signed [itte_pkg::DATA_W-1:0]  value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface itte_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [itte_pkg::DATA_W-1:0]  result;
    logic                                is_last;

    modport source (output valid, output result, output is_last, input ready);
    modport sink   (input valid, input result, input is_last, output ready);
endinterface

// ===== sv/itte_ctrl.sv =====
// Command sequencer: decodes opcodes and walks the heap-layout tree without a stack.
module itte_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  logic [itte_pkg::OP_W-1:0]     cmd_opcode,
    output logic                          cmd_ready,
    input  itte_pkg::dp_status_t          st,
    output itte_pkg::ctrl_cmd_t           ctl
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ENTER = 3'd1;
    localparam logic [2:0] S_RET   = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_PUT   = 3'd5;

    logic [2:0]                  state_reg, state_next;
    logic [2:0]                  resume_reg, resume_next;
    logic [itte_pkg::OP_W-1:0]   op_reg, op_next;
    logic                        is_trav;
    logic [1:0]                  put_sel;

    assign is_trav = (op_reg != itte_pkg::OP_BSTCHK);

    // Single-result source for the current command
    always_comb
    begin
        case (op_reg)
            itte_pkg::OP_APPEND: put_sel = itte_pkg::OSEL_APPEND;
            itte_pkg::OP_HEIGHT: put_sel = itte_pkg::OSEL_HEIGHT;
            default:             put_sel = itte_pkg::OSEL_BST;
        endcase
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        resume_next = resume_reg;
        op_next     = op_reg;
        cmd_ready   = 1'b0;
        ctl         = '0;
        ctl.pos_op  = itte_pkg::POS_HOLD;
        ctl.out_sel = itte_pkg::OSEL_PREV;
        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    ctl.take = 1'b1;
                    op_next  = cmd_opcode;
                    case (cmd_opcode)
                        itte_pkg::OP_INORDER,
                        itte_pkg::OP_PREORDER,
                        itte_pkg::OP_POSTORDER,
                        itte_pkg::OP_BSTCHK:
                            state_next = S_ENTER;
                        itte_pkg::OP_APPEND:
                        begin
                            ctl.append = 1'b1;
                            state_next = S_PUT;
                        end
                        itte_pkg::OP_HEIGHT:
                            state_next = S_PUT;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            // First visit of the cursor node
            S_ENTER:
            begin
                if (st.node_null)
                    state_next = S_RET;
                else if (op_reg == itte_pkg::OP_PREORDER)
                begin
                    ctl.rd_en   = 1'b1;
                    ctl.pos_op  = itte_pkg::POS_LEFT;
                    resume_next = S_ENTER;
                    state_next  = S_EMIT;
                end
                else
                    ctl.pos_op = itte_pkg::POS_LEFT;
            end
            // Back from the cursor node to its parent
            S_RET:
            begin
                if (st.node_root)
                    state_next = S_FIN;
                else if (!st.node_right)
                begin
                    ctl.pos_op = itte_pkg::POS_RIGHT;
                    if (op_reg == itte_pkg::OP_INORDER || op_reg == itte_pkg::OP_BSTCHK)
                    begin
                        ctl.rd_en     = 1'b1;
                        ctl.rd_parent = 1'b1;
                        resume_next   = S_ENTER;
                        state_next    = S_EMIT;
                    end
                    else
                        state_next = S_ENTER;
                end
                else
                begin
                    ctl.pos_op = itte_pkg::POS_UP;
                    if (op_reg == itte_pkg::OP_POSTORDER)
                    begin
                        ctl.rd_en     = 1'b1;
                        ctl.rd_parent = 1'b1;
                        resume_next   = S_RET;
                        state_next    = S_EMIT;
                    end
                end
            end
            // Node value arrived; send the held one on
            S_EMIT:
            begin
                if (!(is_trav && st.prev_vld && !st.out_free))
                begin
                    ctl.consume  = 1'b1;
                    ctl.out_load = is_trav && st.prev_vld;
                    state_next   = resume_reg;
                end
            end
            // Walk done: flush held value or report the check
            S_FIN:
            begin
                if (!is_trav)
                    state_next = S_PUT;
                else if (!st.prev_vld)
                    state_next = S_IDLE;
                else if (st.out_free)
                begin
                    ctl.out_load = 1'b1;
                    ctl.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_PUT:
            begin
                if (st.out_free)
                begin
                    ctl.out_load = 1'b1;
                    ctl.out_sel  = put_sel;
                    ctl.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            resume_reg <= S_IDLE;
            op_reg     <= itte_pkg::OP_INORDER;
        end
        else
        begin
            state_reg  <= state_next;
            resume_reg <= resume_next;
            op_reg     <= op_next;
        end
    end

endmodule

// ===== sv/itte_dp.sv =====
// Datapath: node store, node count, walk cursor, held value and output register.
module itte_dp #(
    parameter int CAPACITY = itte_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [itte_pkg::DATA_W-1:0]  value,
    input  itte_pkg::ctrl_cmd_t                 ctl,
    output itte_pkg::dp_status_t                st,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic signed [itte_pkg::DATA_W-1:0]  out_result,
    output logic                                out_last
);

    localparam int DW = itte_pkg::DATA_W;
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(2 * CAPACITY + 2);

    logic signed [DW-1:0] mem [CAPACITY];

    logic [CW-1:0]        count_reg, count_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic                 prev_vld_reg, prev_vld_next;
    logic signed [DW-1:0] prev_reg;
    logic                 ok_reg, ok_next;
    logic                 full_hit_reg, full_hit_next;
    logic signed [DW-1:0] rd_data_reg;
    logic                 out_valid_reg, out_valid_next;
    logic signed [DW-1:0] out_result_reg;
    logic                 out_last_reg;

    logic                 full;
    logic                 wr_en;
    logic [IW-1:0]        rd_idx, rd_off;
    logic [CW-1:0]        hgt;
    logic signed [DW-1:0] res_mux;

    assign full  = (count_reg == CW'(CAPACITY));
    assign wr_en = ctl.append && !full;

    // Status to controller
    assign st.node_null  = (idx_reg > IW'(count_reg));
    assign st.node_root  = (idx_reg == IW'(1));
    assign st.node_right = idx_reg[0];
    assign st.prev_vld   = prev_vld_reg;
    assign st.out_free   = !out_valid_reg || out_ready;

    // Store address of the node being read (1-based index to 0-based slot)
    assign rd_idx = ctl.rd_parent ? (idx_reg >> 1) : idx_reg;
    assign rd_off = rd_idx - IW'(1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg[AW-1:0]] <= value;
        if (ctl.rd_en)
            rd_data_reg <= mem[rd_off[AW-1:0]];
    end

    // Cursor, count and walk flags
    always_comb
    begin
        count_next    = count_reg;
        idx_next      = idx_reg;
        prev_vld_next = prev_vld_reg;
        ok_next       = ok_reg;
        full_hit_next = full_hit_reg;
        if (wr_en)
            count_next = count_reg + CW'(1);
        if (ctl.append)
            full_hit_next = full;
        case (ctl.pos_op)
            itte_pkg::POS_LEFT:  idx_next = {idx_reg[IW-2:0], 1'b0};
            itte_pkg::POS_RIGHT: idx_next = idx_reg | IW'(1);
            itte_pkg::POS_UP:    idx_next = idx_reg >> 1;
            default:             idx_next = idx_reg;
        endcase
        if (ctl.take)
        begin
            idx_next      = IW'(1);
            prev_vld_next = 1'b0;
            ok_next       = 1'b1;
        end
        if (ctl.consume)
        begin
            prev_vld_next = 1'b1;
            if (prev_vld_reg && (prev_reg > rd_data_reg))
                ok_next = 1'b0;
        end
    end

    // Height: position of the top set bit of the count
    always_comb
    begin
        hgt = '0;
        for (int i = 0; i < CW; i++)
        begin
            if (count_reg[i])
                hgt = CW'(i);
        end
    end

    always_comb
    begin
        case (ctl.out_sel)
            itte_pkg::OSEL_PREV:   res_mux = prev_reg;
            itte_pkg::OSEL_APPEND: res_mux = full_hit_reg ? DW'(1) : '0;
            itte_pkg::OSEL_HEIGHT: res_mux = (count_reg == '0) ? '1 : DW'(hgt);
            itte_pkg::OSEL_BST:    res_mux = ok_reg ? DW'(1) : '0;
            default:               res_mux = prev_reg;
        endcase
    end

    // Output register: a new beat loads, a taken beat empties
    always_comb
    begin
        if (ctl.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.consume)
            prev_reg <= rd_data_reg;
        if (ctl.out_load)
        begin
            out_result_reg <= res_mux;
            out_last_reg   <= ctl.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= IW'(1);
            prev_vld_reg  <= 1'b0;
            ok_reg        <= 1'b1;
            full_hit_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            prev_vld_reg  <= prev_vld_next;
            ok_reg        <= ok_next;
            full_hit_reg  <= full_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;
    assign out_last   = out_last_reg;

endmodule

// ===== sv/implicit_tree_traversal_engine.sv =====
// Top level of the heap-layout tree engine: sequencer, datapath and checks.
//
// Commands arrive on cmd (opcode, value); results leave on rsp (result, is_last).
// One command is worked on at a time; cmd.ready is high only while the
// sequencer is idle. Append and height return one beat with is_last set, loaded
// from the put state into the output register once it is free. In-, pre- and
// post-order return one beat per stored node, the last one marked; an empty
// tree gives no beats. BST check returns one beat with is_last set once its
// in-order walk is done. Opcodes six and seven are taken and dropped.
// While a walk runs the cursor moves one tree edge per step (down, across or
// up, null children included) and each visited node adds one node-store read
// and an emit step, which waits while rsp is stalled. The node store has one
// write and one registered read port.
// Reset clears the node count, so the tree is empty; the store is not cleared.
// A stalled rsp holds its beat in the output register; the walk runs on until
// the next value has to be sent, then waits in place.
module implicit_tree_traversal_engine #(
    parameter int CAPACITY = itte_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    itte_cmd_if.sink    cmd,
    itte_rsp_if.source  rsp
);

    itte_pkg::ctrl_cmd_t  ctl;
    itte_pkg::dp_status_t st;

    itte_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd.valid),
        .cmd_opcode (cmd.opcode),
        .cmd_ready  (cmd.ready),
        .st         (st),
        .ctl        (ctl)
    );

    itte_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (cmd.value),
        .ctl        (ctl),
        .st         (st),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .out_result (rsp.result),
        .out_last   (rsp.is_last)
    );

    // Never overwrite a beat that has not been taken
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> st.out_free)
        else $error("output register loaded while occupied");

    // Command state is reset only on a real command beat
    a_take_beat: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.take |-> (cmd.valid && cmd.ready))
        else $error("walk reset without a command beat");

    // Cursor descends only from a stored node
    a_descend_live: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.pos_op == itte_pkg::POS_LEFT) |-> !st.node_null)
        else $error("cursor descended from an empty slot");

endmodule
